// File: rtl/tlrr_pkg.sv
`default_nettype none
package tlrr_pkg;

   // task table size and derived widths
   localparam int MAX_TASKS = 64;
   localparam int ID_W      = $clog2(MAX_TASKS);
   localparam int CNT_W     = ID_W + 1;
   localparam int NUM_KINDS = 6;
   localparam int NO_FIRST_BONUS_KIND = 3;

   // command codes
   localparam logic [2:0] FN_TICK    = 3'd0;
   localparam logic [2:0] FN_ADD     = 3'd1;
   localparam logic [2:0] FN_REMOVE  = 3'd2;
   localparam logic [2:0] FN_SUSPEND = 3'd3;
   localparam logic [2:0] FN_WAKE    = 3'd4;
   localparam logic [2:0] FN_TERM    = 3'd5;
   localparam logic [2:0] FN_QUERY   = 3'd6;

   // response status codes
   localparam logic [2:0] RS_OK       = 3'd0;
   localparam logic [2:0] RS_BAD_KIND = 3'd1;
   localparam logic [2:0] RS_BAD_ID   = 3'd2;
   localparam logic [2:0] RS_FULL     = 3'd3;
   localparam logic [2:0] RS_NONE_RUN = 3'd4;

   // task states
   localparam logic [2:0] ST_READY      = 3'd0;
   localparam logic [2:0] ST_RUNNING    = 3'd1;
   localparam logic [2:0] ST_WAITING    = 3'd2;
   localparam logic [2:0] ST_TERMINATED = 3'd3;
   localparam logic [2:0] ST_REMOVED    = 3'd4;

   // one task table entry
   typedef struct packed {
      logic [2:0]      status;
      logic            high;
      logic            lng;
      logic [31:0]     ticks;
      logic [15:0]     wleft;
      logic            bonus;
      logic [ID_W-1:0] nxt;
      logic [ID_W-1:0] prv;
   } slot_type;

   // table port request
   typedef struct packed {
      logic            we;
      logic [ID_W-1:0] waddr;
      slot_type        wdata;
      logic [ID_W-1:0] raddr;
   } ram_req_type;

   // result of one command
   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] running_id;
      logic            running_valid;
      logic [ID_W-1:0] new_id;
      logic [2:0]      query_state;
      logic [31:0]     query_wait_total;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_RM1, S_SU1, S_WK1, S_QY1,
      S_TKC, S_TKW, S_TKROT, S_PRE1, S_ROT1, S_ROT2,
      S_TM1, S_TM2, S_TM3,
      S_INS0, S_INS1, S_INS2, S_INS3, S_INS4,
      S_UNL0, S_UNL1, S_UNL2, S_UNL3,
      S_SET0, S_SET1
   } state_type;

endpackage
`default_nettype wire

// File: rtl/two_level_round_robin_scheduler_core.sv
`default_nettype none
// Two-level round-robin task scheduler. A command is taken when start is high
// and busy is low; busy then stays high until its single response beat, which
// is shown for one cycle with rsp_strobe and cannot be stalled by the receiver.
// Every command runs on one sequencer over a task table with one write port
// and one registered read port. Tick and terminate scan every allocated slot,
// and a tick also relinks into its ring each waiting task whose wait ends.
module two_level_round_robin_scheduler_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [2:0]                req_func,
   input  wire logic [tlrr_pkg::ID_W-1:0] req_task_id,
   input  wire logic [2:0]                req_task_kind,
   input  wire logic                      req_high_priority,
   input  wire logic                      req_long_quantum,
   input  wire logic [15:0]               req_wait_ticks,
   output logic                           rsp_strobe,
   output logic [2:0]                     rsp_status,
   output logic [tlrr_pkg::ID_W-1:0]      rsp_running_id,
   output logic                           rsp_running_valid,
   output logic [tlrr_pkg::ID_W-1:0]      rsp_new_id,
   output logic [2:0]                     rsp_query_state,
   output logic [31:0]                    rsp_query_wait_total
);
   import tlrr_pkg::*;

   ram_req_type ram_req;
   slot_type    ram_rdata;
   rsp_type     rsp;
   logic        rsp_load;
   rsp_type     rsp_ff;
   logic        strobe_ff;

   tlrr_slot_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   tlrr_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .func          (req_func),
      .task_id       (req_task_id),
      .task_kind     (req_task_kind),
      .high_priority (req_high_priority),
      .long_quantum  (req_long_quantum),
      .wait_ticks    (req_wait_ticks),
      .ram_req       (ram_req),
      .ram_rdata     (ram_rdata),
      .rsp           (rsp),
      .rsp_load      (rsp_load)
   );

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rsp_load;
      end
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_running_id       = rsp_ff.running_id;
   assign rsp_running_valid    = rsp_ff.running_valid;
   assign rsp_new_id           = rsp_ff.new_id;
   assign rsp_query_state      = rsp_ff.query_state;
   assign rsp_query_wait_total = rsp_ff.query_wait_total;

endmodule
`default_nettype wire

// File: rtl/tlrr_slot_ram.sv
`default_nettype none
module tlrr_slot_ram (
   input  wire logic                  clock,
   input  wire tlrr_pkg::ram_req_type req,
   output tlrr_pkg::slot_type         rdata
);
   import tlrr_pkg::*;

   slot_type mem [MAX_TASKS];
   slot_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
   end

   // registered read, write data forwarded on same address
   always_ff @(posedge clock) begin
      if (req.we && (req.waddr == req.raddr)) begin
         rdata_ff <= req.wdata;
      end else begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/tlrr_seq.sv
`default_nettype none
module tlrr_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [2:0]            func,
   input  wire logic [tlrr_pkg::ID_W-1:0] task_id,
   input  wire logic [2:0]            task_kind,
   input  wire logic                  high_priority,
   input  wire logic                  long_quantum,
   input  wire logic [15:0]           wait_ticks,
   output tlrr_pkg::ram_req_type      ram_req,
   input  wire tlrr_pkg::slot_type    ram_rdata,
   output tlrr_pkg::rsp_type          rsp,
   output logic                       rsp_load
);
   import tlrr_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0]      func_ff, func_in, kind_ff, kind_in;
   logic [ID_W-1:0] tid_ff, tid_in;
   logic            hi_ff, hi_in, lng_ff, lng_in;
   logic [15:0]     wt_ff, wt_in;
   logic [ID_W-1:0] head_ff [2];
   logic [ID_W-1:0] head_in [2];
   logic            pres_ff [2];
   logic            pres_in [2];
   logic            run_hi_ff, run_hi_in;
   logic [CNT_W-1:0] nf_ff, nf_in, wc_ff, wc_in, i_ff, i_in;
   logic [ID_W-1:0] op_id_ff, op_id_in, h_ff, h_in, t_ff, t_in, n_ff, n_in, p_ff, p_in;
   logic            r_ff, r_in, gate_ff, gate_in, term_ff, term_in, wr_ff, wr_in;
   slot_type        w_ff, w_in;
   logic [2:0]      st_ff, st_in, qs_ff, qs_in;
   logic [ID_W-1:0] nid_ff, nid_in;
   logic [31:0]     qt_ff, qt_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff[0] <= '0;
         head_ff[1] <= '0;
         pres_ff[0] <= 1'b0;
         pres_ff[1] <= 1'b0;
         run_hi_ff  <= 1'b1;
         nf_ff      <= CNT_W'(1);
         wc_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         pres_ff    <= pres_in;
         run_hi_ff  <= run_hi_in;
         nf_ff      <= nf_in;
         wc_ff      <= wc_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      func_ff  <= func_in;
      kind_ff  <= kind_in;
      tid_ff   <= tid_in;
      hi_ff    <= hi_in;
      lng_ff   <= lng_in;
      wt_ff    <= wt_in;
      op_id_ff <= op_id_in;
      h_ff     <= h_in;
      t_ff     <= t_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      r_ff     <= r_in;
      gate_ff  <= gate_in;
      term_ff  <= term_in;
      wr_ff    <= wr_in;
      w_ff     <= w_in;
      st_ff    <= st_in;
      qs_ff    <= qs_in;
      nid_ff   <= nid_in;
      qt_ff    <= qt_in;
   end

   logic valid_id, cur_pres, sel_pres, rh_new;
   slot_type wd;

   assign busy = (state_ff != S_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      func_in   = func_ff;
      kind_in   = kind_ff;
      tid_in    = tid_ff;
      hi_in     = hi_ff;
      lng_in    = lng_ff;
      wt_in     = wt_ff;
      head_in   = head_ff;
      pres_in   = pres_ff;
      run_hi_in = run_hi_ff;
      nf_in     = nf_ff;
      wc_in     = wc_ff;
      op_id_in  = op_id_ff;
      h_in      = h_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      r_in      = r_ff;
      gate_in   = gate_ff;
      term_in   = term_ff;
      wr_in     = wr_ff;
      w_in      = w_ff;
      st_in     = st_ff;
      qs_in     = qs_ff;
      nid_in    = nid_ff;
      qt_in     = qt_ff;
      wd        = ram_rdata;
      ram_req.we    = 1'b0;
      ram_req.waddr = op_id_ff;
      ram_req.wdata = ram_rdata;
      ram_req.raddr = op_id_ff;
      rsp_load  = 1'b0;
      rsp.status           = st_ff;
      rsp.running_id       = '0;
      rsp.running_valid    = 1'b0;
      rsp.new_id           = nid_ff;
      rsp.query_state      = qs_ff;
      rsp.query_wait_total = qt_ff;

      valid_id = (tid_ff != '0) && ({1'b0, tid_ff} < nf_ff);
      cur_pres = pres_ff[run_hi_ff];
      sel_pres = cur_pres;
      rh_new   = run_hi_ff;
      if (!sel_pres) begin
         if (pres_ff[1]) begin
            rh_new = 1'b1;
         end else if (pres_ff[0]) begin
            rh_new = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = func;
               tid_in   = task_id;
               kind_in  = task_kind;
               hi_in    = high_priority;
               lng_in   = long_quantum;
               wt_in    = wait_ticks;
               st_in    = RS_OK;
               qs_in    = ST_READY;
               nid_in   = '0;
               qt_in    = '0;
               state_in = S_DEC;
            end
         end

         // decode the command
         S_DEC: begin
            ram_req.raddr = tid_ff;
            op_id_in      = tid_ff;
            state_in      = S_SET0;
            case (func_ff)
               FN_TICK: begin
                  wr_in    = cur_pres;
                  gate_in  = (wc_ff != '0);
                  term_in  = 1'b0;
                  i_in     = CNT_W'(1);
                  state_in = S_TKC;
               end
               FN_ADD: begin
                  if (kind_ff < 3'd1 || kind_ff > 3'(NUM_KINDS)) begin
                     st_in = RS_BAD_KIND;
                  end else if (nf_ff >= CNT_W'(MAX_TASKS)) begin
                     st_in = RS_FULL;
                  end else begin
                     wd.status = ST_READY;
                     wd.high   = hi_ff;
                     wd.lng    = lng_ff;
                     wd.ticks  = '0;
                     wd.wleft  = '0;
                     wd.bonus  = lng_ff && (kind_ff != 3'(NO_FIRST_BONUS_KIND));
                     wd.nxt    = '0;
                     wd.prv    = '0;
                     ram_req.we    = 1'b1;
                     ram_req.waddr = nf_ff[ID_W-1:0];
                     ram_req.wdata = wd;
                     op_id_in  = nf_ff[ID_W-1:0];
                     nid_in    = nf_ff[ID_W-1:0];
                     nf_in     = nf_ff + CNT_W'(1);
                     ret_in    = S_SET0;
                     state_in  = S_INS0;
                  end
               end
               FN_REMOVE: begin
                  if (!valid_id) st_in = RS_BAD_ID;
                  else state_in = S_RM1;
               end
               FN_SUSPEND: begin
                  if (!cur_pres) begin
                     st_in = RS_NONE_RUN;
                  end else begin
                     ram_req.raddr = head_ff[run_hi_ff];
                     op_id_in      = head_ff[run_hi_ff];
                     state_in      = S_SU1;
                  end
               end
               FN_WAKE: begin
                  if (!valid_id) st_in = RS_BAD_ID;
                  else state_in = S_WK1;
               end
               FN_TERM: begin
                  if (!cur_pres) begin
                     st_in = RS_NONE_RUN;
                  end else begin
                     op_id_in = head_ff[run_hi_ff];
                     wr_in    = 1'b0;
                     gate_in  = 1'b0;
                     term_in  = 1'b1;
                     i_in     = CNT_W'(1);
                     state_in = S_TKC;
                  end
               end
               FN_QUERY: begin
                  if (!valid_id) st_in = RS_BAD_ID;
                  else state_in = S_QY1;
               end
               default: begin
                  state_in = S_SET0;
               end
            endcase
         end

         // remove
         S_RM1: begin
            if (ram_rdata.status == ST_REMOVED) begin
               st_in    = RS_BAD_ID;
               state_in = S_SET0;
            end else begin
               wd.status     = ST_REMOVED;
               ram_req.we    = 1'b1;
               ram_req.wdata = wd;
               state_in      = S_SET0;
               if (ram_rdata.status == ST_READY || ram_rdata.status == ST_RUNNING) begin
                  ret_in   = S_SET0;
                  state_in = S_UNL0;
               end else if (ram_rdata.status == ST_WAITING && wc_ff != '0) begin
                  wc_in = wc_ff - CNT_W'(1);
               end
            end
         end

         // suspend running task
         S_SU1: begin
            wd.status     = ST_WAITING;
            wd.wleft      = wt_ff;
            ram_req.we    = 1'b1;
            ram_req.wdata = wd;
            wc_in         = wc_ff + CNT_W'(1);
            ret_in        = S_SET0;
            state_in      = S_UNL0;
         end

         // wake
         S_WK1: begin
            state_in = S_SET0;
            if (ram_rdata.status == ST_WAITING) begin
               wd.status     = ST_READY;
               wd.wleft      = '0;
               ram_req.we    = 1'b1;
               ram_req.wdata = wd;
               if (wc_ff != '0) wc_in = wc_ff - CNT_W'(1);
               ret_in   = S_SET0;
               state_in = S_INS0;
            end
         end

         // query
         S_QY1: begin
            qs_in    = ram_rdata.status;
            qt_in    = ram_rdata.ticks;
            state_in = S_SET0;
         end

         // slot scan: aging and wait countdown
         S_TKC: begin
            ram_req.raddr = i_ff[ID_W-1:0];
            if (i_ff < nf_ff) begin
               state_in = S_TKW;
            end else if (term_ff) begin
               state_in = S_TM1;
            end else begin
               state_in = S_TKROT;
            end
         end
         S_TKW: begin
            ram_req.waddr = i_ff[ID_W-1:0];
            i_in          = i_ff + CNT_W'(1);
            state_in      = S_TKC;
            if (ram_rdata.status == ST_READY) begin
               if (ram_rdata.ticks != '1) begin
                  wd.ticks      = ram_rdata.ticks + 32'd1;
                  ram_req.we    = 1'b1;
                  ram_req.wdata = wd;
               end
            end else if (ram_rdata.status == ST_WAITING && gate_ff) begin
               wd.wleft      = ram_rdata.wleft - 16'd1;
               ram_req.we    = 1'b1;
               if (wd.wleft == '0) begin
                  wd.status = ST_READY;
                  if (wc_ff != '0) wc_in = wc_ff - CNT_W'(1);
                  op_id_in  = i_ff[ID_W-1:0];
                  ret_in    = S_TKC;
                  state_in  = S_INS0;
               end
               ram_req.wdata = wd;
            end
         end

         // preempt or rotate after a tick
         S_TKROT: begin
            state_in = S_SET0;
            if (wr_ff) begin
               if (!run_hi_ff && pres_ff[1]) begin
                  run_hi_in = 1'b1;
                  if (pres_ff[0]) begin
                     ram_req.raddr = head_ff[0];
                     op_id_in      = head_ff[0];
                     state_in      = S_PRE1;
                  end
               end else if (pres_ff[run_hi_ff]) begin
                  ram_req.raddr = head_ff[run_hi_ff];
                  op_id_in      = head_ff[run_hi_ff];
                  state_in      = S_ROT1;
               end
            end
         end
         S_PRE1: begin
            wd.status     = ST_READY;
            ram_req.we    = 1'b1;
            ram_req.wdata = wd;
            state_in      = S_SET0;
         end
         S_ROT1: begin
            ram_req.we = 1'b1;
            state_in   = S_SET0;
            if (ram_rdata.bonus) begin
               wd.bonus = 1'b0;
            end else begin
               wd.status              = ST_READY;
               head_in[run_hi_ff]     = ram_rdata.nxt;
               ram_req.raddr          = ram_rdata.nxt;
               op_id_in               = ram_rdata.nxt;
               state_in               = S_ROT2;
            end
            ram_req.wdata = wd;
         end
         S_ROT2: begin
            wd.bonus      = ram_rdata.lng;
            ram_req.we    = 1'b1;
            ram_req.wdata = wd;
            state_in      = S_SET0;
         end

         // terminate running task
         S_TM1: begin
            state_in = S_TM2;
         end
         S_TM2: begin
            wd.status     = ST_TERMINATED;
            ram_req.we    = 1'b1;
            ram_req.wdata = wd;
            ret_in        = S_TM3;
            state_in      = S_UNL0;
         end
         S_TM3: begin
            if (pres_ff[1]) run_hi_in = 1'b1;
            else if (pres_ff[0]) run_hi_in = 1'b0;
            state_in = S_SET0;
         end

         // ring insert at tail
         S_INS0: begin
            state_in = S_INS1;
         end
         S_INS1: begin
            r_in = ram_rdata.high;
            if (!pres_ff[ram_rdata.high]) begin
               wd.nxt        = op_id_ff;
               wd.prv        = op_id_ff;
               ram_req.we    = 1'b1;
               ram_req.wdata = wd;
               head_in[ram_rdata.high] = op_id_ff;
               pres_in[ram_rdata.high] = 1'b1;
               state_in      = ret_ff;
            end else begin
               w_in          = ram_rdata;
               h_in          = head_ff[ram_rdata.high];
               ram_req.raddr = head_ff[ram_rdata.high];
               state_in      = S_INS2;
            end
         end
         S_INS2: begin
            wd.prv        = op_id_ff;
            ram_req.we    = 1'b1;
            ram_req.waddr = h_ff;
            ram_req.wdata = wd;
            t_in          = ram_rdata.prv;
            ram_req.raddr = ram_rdata.prv;
            state_in      = S_INS3;
         end
         S_INS3: begin
            wd.nxt        = op_id_ff;
            ram_req.we    = 1'b1;
            ram_req.waddr = t_ff;
            ram_req.wdata = wd;
            state_in      = S_INS4;
         end
         S_INS4: begin
            wd            = w_ff;
            wd.prv        = t_ff;
            wd.nxt        = h_ff;
            ram_req.we    = 1'b1;
            ram_req.wdata = wd;
            state_in      = ret_ff;
         end

         // ring unlink
         S_UNL0: begin
            state_in = S_UNL1;
         end
         S_UNL1: begin
            r_in = ram_rdata.high;
            n_in = ram_rdata.nxt;
            p_in = ram_rdata.prv;
            if (ram_rdata.nxt == op_id_ff) begin
               pres_in[ram_rdata.high] = 1'b0;
               state_in = ret_ff;
            end else begin
               ram_req.raddr = ram_rdata.prv;
               state_in      = S_UNL2;
            end
         end
         S_UNL2: begin
            wd.nxt        = n_ff;
            ram_req.we    = 1'b1;
            ram_req.waddr = p_ff;
            ram_req.wdata = wd;
            ram_req.raddr = n_ff;
            state_in      = S_UNL3;
         end
         S_UNL3: begin
            wd.prv        = p_ff;
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = wd;
            if (head_ff[r_ff] == op_id_ff) head_in[r_ff] = n_ff;
            state_in = ret_ff;
         end

         // dispatch and respond
         S_SET0: begin
            run_hi_in     = rh_new;
            ram_req.raddr = head_ff[rh_new];
            op_id_in      = head_ff[rh_new];
            state_in      = S_SET1;
         end
         S_SET1: begin
            if (cur_pres) begin
               wd.status     = ST_RUNNING;
               ram_req.we    = 1'b1;
               ram_req.wdata = wd;
               rsp.running_id    = head_ff[run_hi_ff];
               rsp.running_valid = 1'b1;
            end
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
import tlrr_pkg::*;

// one command beat as driven on the request ports
typedef struct {
   logic [2:0]  fn;
   logic [5:0]  id;
   logic [2:0]  kind;
   logic        hi;
   logic        lng;
   logic [15:0] wt;
} sched_cmd;

// scheduler shadow: predicts each response and checks it against the block
class sched_shadow;
   logic [2:0]  t_status [MAX_TASKS];
   bit          t_high   [MAX_TASKS];
   bit          t_long   [MAX_TASKS];
   logic [31:0] t_ready  [MAX_TASKS];
   logic [15:0] t_wleft  [MAX_TASKS];
   bit          t_bonus  [MAX_TASKS];
   int          t_next   [MAX_TASKS];
   int          t_prev   [MAX_TASKS];
   int          high_head, low_head;
   bit          high_on, low_on, run_high;
   int          next_id, wait_cnt;
   rsp_type     pending_rsp[$];
   int          errors;

   function new();
      high_head = 0; low_head = 0;
      high_on = 0; low_on = 0; run_high = 1;
      next_id = 1; wait_cnt = 0; errors = 0;
   endfunction

   function bit ring_on(bit r);
      return r ? high_on : low_on;
   endfunction

   function int ring_head(bit r);
      return r ? high_head : low_head;
   endfunction

   function void put_head(bit r, int v);
      if (r) high_head = v; else low_head = v;
   endfunction

   function void put_on(bit r, bit v);
      if (r) high_on = v; else low_on = v;
   endfunction

   function bit running(output int id);
      id = 0;
      if (!ring_on(run_high)) return 0;
      id = ring_head(run_high);
      return 1;
   endfunction

   // append at tail of the task's ring
   function void link(int id);
      bit r;
      int h, t;
      r = t_high[id];
      if (!ring_on(r)) begin
         t_next[id] = id; t_prev[id] = id;
         put_head(r, id); put_on(r, 1);
      end else begin
         h = ring_head(r); t = t_prev[h];
         t_prev[id] = t; t_next[id] = h;
         t_next[t] = id; t_prev[h] = id;
      end
   endfunction

   function void unlink(int id);
      bit r;
      int n, p;
      r = t_high[id]; n = t_next[id]; p = t_prev[id];
      if (n == id) begin
         put_on(r, 0);
         return;
      end
      t_next[p] = n; t_prev[n] = p;
      if (ring_head(r) == id) put_head(r, n);
   endfunction

   function void age_ready();
      for (int i = 1; i < next_id; i++)
         if (t_status[i] == ST_READY && t_ready[i] != 32'hFFFF_FFFF) t_ready[i]++;
   endfunction

   function void rotate(bit r);
      int h;
      h = ring_head(r);
      if (t_bonus[h]) begin
         t_bonus[h] = 0;
         return;
      end
      t_status[h] = ST_READY;
      h = t_next[h];
      put_head(r, h);
      t_bonus[h] = t_long[h];
   endfunction

   function void tick();
      int cur;
      bit was;
      was = running(cur);
      age_ready();
      if (wait_cnt != 0)
         for (int i = 1; i < next_id; i++) begin
            if (t_status[i] != ST_WAITING) continue;
            t_wleft[i] = t_wleft[i] - 16'd1;
            if (t_wleft[i] == 0) begin
               t_status[i] = ST_READY;
               link(i);
               if (wait_cnt != 0) wait_cnt--;
            end
         end
      if (was) begin
         if (!run_high && high_on) begin
            if (low_on) t_status[low_head] = ST_READY;
            run_high = 1;
         end else if (run_high && high_on) rotate(1);
         else if (!run_high && low_on) rotate(0);
      end
   endfunction

   // accepted command beat: advance shadow state, queue expected response
   function void note(sched_cmd c);
      rsp_type r;
      int cur, id;
      bit ok_id;
      r = '0;
      ok_id = c.id >= 1 && c.id < next_id;
      case (c.fn)
         FN_TICK: tick();
         FN_ADD: begin
            if (c.kind < 1 || c.kind > NUM_KINDS) r.status = RS_BAD_KIND;
            else if (next_id >= MAX_TASKS) r.status = RS_FULL;
            else begin
               id = next_id++;
               t_status[id] = ST_READY; t_high[id] = c.hi; t_long[id] = c.lng;
               t_ready[id] = 0; t_wleft[id] = 0;
               t_bonus[id] = c.lng && c.kind != NO_FIRST_BONUS_KIND;
               link(id);
               r.new_id = ID_W'(id);
            end
         end
         FN_REMOVE: begin
            if (!ok_id || t_status[c.id] == ST_REMOVED) r.status = RS_BAD_ID;
            else begin
               if (t_status[c.id] == ST_READY || t_status[c.id] == ST_RUNNING)
                  unlink(c.id);
               else if (t_status[c.id] == ST_WAITING && wait_cnt != 0) wait_cnt--;
               t_status[c.id] = ST_REMOVED;
            end
         end
         FN_SUSPEND: begin
            if (!running(cur)) r.status = RS_NONE_RUN;
            else begin
               t_wleft[cur] = c.wt; t_status[cur] = ST_WAITING;
               wait_cnt++;
               unlink(cur);
            end
         end
         FN_WAKE: begin
            if (!ok_id) r.status = RS_BAD_ID;
            else if (t_status[c.id] == ST_WAITING) begin
               t_wleft[c.id] = 0; t_status[c.id] = ST_READY;
               link(c.id);
               if (wait_cnt != 0) wait_cnt--;
            end
         end
         FN_TERM: begin
            if (!running(cur)) r.status = RS_NONE_RUN;
            else begin
               age_ready();
               t_status[cur] = ST_TERMINATED;
               unlink(cur);
               if (high_on) run_high = 1;
               else if (low_on) run_high = 0;
            end
         end
         FN_QUERY: begin
            if (!ok_id) r.status = RS_BAD_ID;
            else begin
               r.query_state = t_status[c.id];
               r.query_wait_total = t_ready[c.id];
            end
         end
         default: ;
      endcase
      // dispatch onto a non-empty ring
      if (!(run_high ? high_on : low_on)) begin
         if (high_on) run_high = 1;
         else if (low_on) run_high = 0;
      end
      if (running(cur)) begin
         t_status[cur] = ST_RUNNING;
         r.running_id = ID_W'(cur);
         r.running_valid = 1;
      end
      pending_rsp.push_back(r);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // response beat from the block
   task check(rsp_type got);
      rsp_type w;
      if (pending_rsp.size() == 0) begin
         report("unexpected response beat", 1, 0);
         return;
      end
      w = pending_rsp.pop_front();
      if (got.status != w.status) report("status", 32'(got.status), 32'(w.status));
      if (got.running_id != w.running_id)
         report("running_id", 32'(got.running_id), 32'(w.running_id));
      if (got.running_valid != w.running_valid)
         report("running_valid", 32'(got.running_valid), 32'(w.running_valid));
      if (got.new_id != w.new_id) report("new_id", 32'(got.new_id), 32'(w.new_id));
      if (got.query_state != w.query_state)
         report("query_state", 32'(got.query_state), 32'(w.query_state));
      if (got.query_wait_total != w.query_wait_total)
         report("query_wait_total", got.query_wait_total, w.query_wait_total);
   endtask
endclass

module tb;
   logic              clock, reset, start;
   logic              busy;
   logic [2:0]        req_func, req_task_kind;
   logic [ID_W-1:0]   req_task_id;
   logic              req_high_priority, req_long_quantum;
   logic [15:0]       req_wait_ticks;
   logic              rsp_strobe, rsp_running_valid;
   logic [2:0]        rsp_status, rsp_query_state;
   logic [ID_W-1:0]   rsp_running_id, rsp_new_id;
   logic [31:0]       rsp_query_wait_total;

   sched_shadow shadow = new();
   int idle_pct;

   two_level_round_robin_scheduler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_task_id(req_task_id), .req_task_kind(req_task_kind),
      .req_high_priority(req_high_priority), .req_long_quantum(req_long_quantum),
      .req_wait_ticks(req_wait_ticks), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_running_id(rsp_running_id),
      .rsp_running_valid(rsp_running_valid), .rsp_new_id(rsp_new_id),
      .rsp_query_state(rsp_query_state), .rsp_query_wait_total(rsp_query_wait_total)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         shadow.check('{rsp_status, rsp_running_id, rsp_running_valid, rsp_new_id,
                        rsp_query_state, rsp_query_wait_total});
   end

   // drive one beat, holding start until accepted
   task send(sched_cmd c);
      // sender idle cycles, counted only while the block is ready
      if (idle_pct > 0) begin
         start <= 0;
         @(posedge clock);
         while (busy || $urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_func <= c.fn; req_task_id <= c.id; req_task_kind <= c.kind;
      req_high_priority <= c.hi; req_long_quantum <= c.lng; req_wait_ticks <= c.wt;
      start <= 1;
      do @(posedge clock); while (busy);
      shadow.note(c);
   endtask

   task cmd(logic [2:0] fn, logic [5:0] id = 0, logic [2:0] kind = 1,
            logic hi = 0, logic lng = 0, logic [15:0] wt = 1);
      sched_cmd c;
      c = '{fn, id, kind, hi, lng, wt};
      send(c);
   endtask

   // random command, weighted toward ticks and live ids
   task random_cmd();
      sched_cmd c;
      int p;
      p = $urandom_range(99);
      c.fn = p < 34 ? FN_TICK : p < 43 ? FN_ADD : p < 49 ? FN_REMOVE :
             p < 61 ? FN_SUSPEND : p < 73 ? FN_WAKE : p < 79 ? FN_TERM :
             p < 97 ? FN_QUERY : 3'd7;
      c.id = $urandom_range(9) == 0 ? 6'($urandom_range(63))
                                    : 6'($urandom_range(1, shadow.next_id));
      c.kind = $urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(1, 6));
      c.hi = 1'($urandom_range(1));
      c.lng = 1'($urandom_range(1));
      p = $urandom_range(9);
      c.wt = p < 7 ? 16'($urandom_range(1, 6)) : p < 9 ? 16'($urandom) : 16'd0;
      send(c);
   endtask

   initial begin
      start = 0; reset = 1;
      req_func = FN_TICK; req_task_id = 0; req_task_kind = 0;
      req_high_priority = 0; req_long_quantum = 0; req_wait_ticks = 0;
      idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty scheduler, bad arguments, every command
      cmd(FN_TICK);
      cmd(FN_SUSPEND);
      cmd(FN_TERM);
      cmd(FN_QUERY, 0);
      cmd(FN_WAKE, 63);
      cmd(FN_REMOVE, 1);
      cmd(FN_ADD, 0, 0);
      cmd(FN_ADD, 0, 7);
      cmd(FN_ADD, 0, 1, 0, 1);
      cmd(FN_ADD, 0, 3, 1, 1);
      cmd(FN_ADD, 0, 6, 1, 0);
      cmd(FN_ADD, 0, 2, 0, 0);
      cmd(FN_TICK);
      cmd(FN_TICK);
      cmd(FN_SUSPEND, 0, 1, 0, 0, 16'd0);
      cmd(FN_SUSPEND, 0, 1, 0, 0, 16'd1);
      cmd(FN_TICK);
      cmd(FN_QUERY, 2);
      cmd(FN_WAKE, 1);
      cmd(FN_WAKE, 4);
      cmd(FN_TERM);
      cmd(FN_REMOVE, 3);
      cmd(FN_REMOVE, 3);
      cmd(FN_QUERY, 3);
      cmd(3'd7, 6'h3F, 3'h7, 1, 1, 16'hFFFF);

      // random: sender idling 15%, then 66%, then none
      idle_pct = 15;
      repeat (310) random_cmd();
      idle_pct = 66;
      repeat (310) random_cmd();
      idle_pct = 0;
      repeat (310) random_cmd();
      start <= 0;

      while (shadow.pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (shadow.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// File: files.f
rtl/tlrr_pkg.sv
rtl/tlrr_slot_ram.sv
rtl/tlrr_seq.sv
rtl/two_level_round_robin_scheduler_core.sv
bench/tb.sv
